>>> rtl/gwm_pkg.sv
// Package with the shared constants, types and byte compare function of the glob matcher.
package gwm_pkg;

   localparam int PATTERN_DEPTH = 64;
   localparam int SUBJECT_DEPTH = 256;

   localparam logic [3:0] OPTIONS_RESET = 4'd14;

   // Bit positions in the match options register.
   localparam int OPT_FOLD  = 0;
   localparam int OPT_ONE   = 1;
   localparam int OPT_DIGIT = 2;
   localparam int OPT_RUN   = 3;

   localparam logic [7:0] CHAR_STAR     = 8'h2A;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_HASH     = 8'h23;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   typedef struct packed {
      logic matched;
      logic overflow;
   } result_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic [3:0] opt);
      logic [7:0] r;
      r = c;
      if (opt[OPT_FOLD] && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic byte_fits(input logic [7:0] sc, input logic [7:0] pc,
                                      input logic [3:0] opt);
      logic r;
      r = 1'b0;
      if (fold_char(sc, opt) == fold_char(pc, opt)) begin
         r = 1'b1;
      end
      if (opt[OPT_ONE] && pc == CHAR_QUESTION) begin
         r = 1'b1;
      end
      if (opt[OPT_DIGIT] && pc == CHAR_HASH && sc >= CHAR_ZERO && sc <= CHAR_NINE) begin
         r = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> rtl/gwm_if.sv
// Channel interfaces for requests, responses and the options register write port.
interface gwm_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_code;
   logic       no_char;
   logic       last;
   modport source (output valid, kind, char_code, no_char, last, input ready);
   modport sink (input valid, kind, char_code, no_char, last, output ready);
endinterface

interface gwm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic overflow;
   modport source (output valid, matched, overflow, input ready);
   modport sink (input valid, matched, overflow, output ready);
endinterface

interface gwm_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/gwm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gwm_engine.sv
// Match sequencer: walks the pattern and subject stores with one shared byte comparer.
module gwm_engine #(
   parameter int PATTERN_DEPTH = gwm_pkg::PATTERN_DEPTH,
   parameter int SUBJECT_DEPTH = gwm_pkg::SUBJECT_DEPTH,
   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1,
   localparam int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1,
   localparam int PW  = $clog2(PATTERN_DEPTH + 1),
   localparam int SW  = $clog2(SUBJECT_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PW-1:0]         start_plen,
   input  logic [SW-1:0]         start_slen,
   input  logic                  start_ovf,
   input  logic [3:0]            options,
   output logic [PAW-1:0]        pat_addr,
   input  logic [7:0]            pat_rdata,
   output logic [SAW-1:0]        sub_addr,
   input  logic [7:0]            sub_rdata,
   output logic                  idle,
   output logic                  res_valid,
   input  logic                  res_take,
   output gwm_pkg::result_type   result
);

   localparam int CW = ((PW > SW) ? PW : SW) + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HEAD_RD, ST_HEAD, ST_LIT, ST_STAR_RD, ST_STAR,
      ST_SCAN_RD, ST_SCAN, ST_SETUP, ST_SEG_RD, ST_SEG, ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [PW-1:0] p_ff, p_in, q_ff, q_in, i_ff, i_in, plen_ff, plen_in;
   logic [SW-1:0] s_ff, s_in, k_ff, k_in, slen_ff, slen_in;
   logic [7:0]    pc_ff, pc_in;
   logic          anch_ff, anch_in, hit_ff, hit_in, ovf_ff, ovf_in;

   logic [CW-1:0] n_w, rest_w, k_end_w;
   logic [PW-1:0] pi_w;
   logic [SW-1:0] ki_w;
   logic          fit_w;

   assign n_w     = CW'(q_ff) - CW'(p_ff);
   assign rest_w  = CW'(slen_ff) - CW'(s_ff);
   assign k_end_w = CW'(k_ff) + CW'(1) + n_w;
   assign pi_w    = p_ff + i_ff;
   assign ki_w    = k_ff + SW'(i_ff);
   assign fit_w   = gwm_pkg::byte_fits(sub_rdata, (state_ff == ST_LIT) ? pc_ff : pat_rdata,
                                       options);

   always_comb begin
      pat_addr = PAW'(p_ff);
      sub_addr = SAW'(s_ff);
      if (state_ff == ST_SCAN_RD) begin
         pat_addr = PAW'(q_ff);
      end else if (state_ff == ST_SEG_RD) begin
         pat_addr = PAW'(pi_w);
         sub_addr = SAW'(ki_w);
      end
   end

   always_comb begin
      state_in = state_ff;
      p_in = p_ff; q_in = q_ff; i_in = i_ff; plen_in = plen_ff;
      s_in = s_ff; k_in = k_ff; slen_in = slen_ff;
      pc_in = pc_ff; anch_in = anch_ff; hit_in = hit_ff; ovf_in = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               plen_in = start_plen;
               slen_in = start_slen;
               ovf_in  = start_ovf;
               p_in    = '0;
               s_in    = '0;
               hit_in  = 1'b0;
               state_in = start_ovf ? ST_DONE : ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: state_in = ST_HEAD;
         ST_HEAD: begin
            if (options[gwm_pkg::OPT_RUN] && p_ff < plen_ff
                && pat_rdata == gwm_pkg::CHAR_STAR) begin
               p_in = p_ff + PW'(1);
               state_in = ST_STAR_RD;
            end else if (p_ff == plen_ff) begin
               hit_in = (s_ff == slen_ff);
               state_in = ST_DONE;
            end else if (s_ff == slen_ff) begin
               state_in = ST_DONE;
            end else begin
               pc_in = pat_rdata;
               state_in = ST_LIT;
            end
         end
         ST_LIT: begin
            if (fit_w) begin
               p_in = p_ff + PW'(1);
               s_in = s_ff + SW'(1);
               state_in = ST_HEAD_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_STAR_RD: state_in = ST_STAR;
         ST_STAR: begin
            if (p_ff < plen_ff && pat_rdata == gwm_pkg::CHAR_STAR) begin
               p_in = p_ff + PW'(1);
               state_in = ST_STAR_RD;
            end else if (p_ff == plen_ff) begin
               hit_in = 1'b1;
               state_in = ST_DONE;
            end else if (s_ff == slen_ff) begin
               state_in = ST_DONE;
            end else begin
               q_in = p_ff + PW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = (q_ff == plen_ff) ? ST_SETUP : ST_SCAN;
         ST_SCAN: begin
            if (pat_rdata == gwm_pkg::CHAR_STAR) begin
               state_in = ST_SETUP;
            end else begin
               q_in = q_ff + PW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SETUP: begin
            i_in = '0;
            if (rest_w < n_w) begin
               state_in = ST_DONE;
            end else if (q_ff == plen_ff) begin
               anch_in = 1'b1;
               k_in = SW'(CW'(slen_ff) - n_w);
               state_in = ST_SEG_RD;
            end else begin
               anch_in = 1'b0;
               k_in = s_ff;
               state_in = ST_SEG_RD;
            end
         end
         ST_SEG_RD: state_in = ST_SEG;
         ST_SEG: begin
            if (fit_w) begin
               if (CW'(i_ff) + CW'(1) == n_w) begin
                  if (anch_ff) begin
                     hit_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     s_in = SW'(CW'(k_ff) + n_w);
                     p_in = q_ff;
                     state_in = ST_HEAD_RD;
                  end
               end else begin
                  i_in = i_ff + PW'(1);
                  state_in = ST_SEG_RD;
               end
            end else if (anch_ff || k_end_w > CW'(slen_ff)) begin
               state_in = ST_DONE;
            end else begin
               k_in = k_ff + SW'(1);
               i_in = '0;
               state_in = ST_SEG_RD;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      p_ff <= p_in; q_ff <= q_in; i_ff <= i_in; plen_ff <= plen_in;
      s_ff <= s_in; k_ff <= k_in; slen_ff <= slen_in;
      pc_ff <= pc_in; anch_ff <= anch_in; hit_ff <= hit_in; ovf_ff <= ovf_in;
   end

   assign idle            = (state_ff == ST_IDLE);
   assign res_valid       = (state_ff == ST_DONE);
   assign result.matched  = hit_ff;
   assign result.overflow = ovf_ff;

endmodule

>>> rtl/glob_wildcard_matcher_top.sv
// Top level of the glob wildcard matcher: loaders, stores, match sequencer and response register.
// Requests load pattern bytes and subject bytes, one per cycle, into two RAMs; the subject
// request marked last starts a match and yields one response with matched and overflow.
// While a match runs the request channel is not ready. One shared byte comparer walks both
// RAMs through their single registered read ports, so every pattern or subject byte the match
// inspects passes a read state and a decision state: a literal step reads, captures the
// pattern byte and compares; each star, each pattern byte scanned up to the next star and
// each byte compared at each trial offset of a segment is read and decided, and each segment
// is set up once, so the worst case grows as subject length times segment length. An
// overflowed store sends the sequencer from idle straight to done. A new request is accepted
// as soon as the sequencer is idle, even while the last response still waits on the response
// channel. The options register may be written at any time the block is idle and is always ready.
module glob_wildcard_matcher_top #(
   parameter int PATTERN_DEPTH = gwm_pkg::PATTERN_DEPTH,
   parameter int SUBJECT_DEPTH = gwm_pkg::SUBJECT_DEPTH
) (
   input  logic  clock,
   input  logic  reset,
   gwm_req_if.sink   req_chan,
   gwm_rsp_if.source rsp_chan,
   gwm_csr_if.sink   csr_chan
);

   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;
   localparam int PW  = $clog2(PATTERN_DEPTH + 1);
   localparam int SW  = $clog2(SUBJECT_DEPTH + 1);

   // Loader state: lengths, overflow flags and whether the pattern has been closed.
   logic [3:0]    options_ff, options_in;
   logic [PW-1:0] plen_ff, plen_in, pbase_w;
   logic [SW-1:0] slen_ff, slen_in, slen_new_w;
   logic          pov_ff, pov_in, pov_base_w, sov_ff, sov_in, sov_new_w, closed_ff, closed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   gwm_pkg::result_type rsp_ff, rsp_in;

   logic accept, has_byte, pat_we, sub_we, start;
   logic eng_idle, eng_valid, eng_take;
   logic [PAW-1:0] pat_raddr;
   logic [SAW-1:0] sub_raddr;
   logic [7:0]     pat_rdata, sub_rdata;
   gwm_pkg::result_type eng_result;

   assign req_chan.ready = eng_idle;
   assign csr_chan.ready = 1'b1;
   assign accept   = req_chan.valid && eng_idle;
   assign has_byte = !req_chan.no_char;

   // A pattern request after a closed pattern starts a fresh pattern.
   assign pbase_w    = closed_ff ? '0 : plen_ff;
   assign pov_base_w = closed_ff ? 1'b0 : pov_ff;
   assign pat_we     = accept && !req_chan.kind && has_byte && (pbase_w < PW'(PATTERN_DEPTH));
   assign sub_we     = accept && req_chan.kind && has_byte && (slen_ff < SW'(SUBJECT_DEPTH));
   assign slen_new_w = sub_we ? slen_ff + SW'(1) : slen_ff;
   assign sov_new_w  = sov_ff || (accept && req_chan.kind && has_byte && !sub_we);
   assign start      = accept && req_chan.kind && req_chan.last;

   always_comb begin
      options_in = options_ff;
      plen_in = plen_ff; pov_in = pov_ff; closed_in = closed_ff;
      slen_in = slen_ff; sov_in = sov_ff;
      if (csr_chan.valid) begin
         options_in = csr_chan.data;
      end
      if (accept && !req_chan.kind) begin
         plen_in   = pat_we ? pbase_w + PW'(1) : pbase_w;
         pov_in    = pov_base_w || (has_byte && !pat_we);
         closed_in = req_chan.last;
      end
      if (accept && req_chan.kind) begin
         // The subject is consumed by the match that its last request starts.
         slen_in = req_chan.last ? '0 : slen_new_w;
         sov_in  = req_chan.last ? 1'b0 : sov_new_w;
      end
   end

   // The response register frees the sequencer by taking a finished result once it is empty or being read.
   assign eng_take = eng_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (eng_take) begin
         rsp_in = eng_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         options_ff   <= gwm_pkg::OPTIONS_RESET;
         plen_ff      <= '0;
         pov_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         slen_ff      <= '0;
         sov_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         options_ff   <= options_in;
         plen_ff      <= plen_in;
         pov_ff       <= pov_in;
         closed_ff    <= closed_in;
         slen_ff      <= slen_in;
         sov_ff       <= sov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.matched  = rsp_ff.matched;
   assign rsp_chan.overflow = rsp_ff.overflow;

   gwm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (PAW'(pbase_w)),
      .wr_data (req_chan.char_code),
      .rd_addr (pat_raddr),
      .rd_data (pat_rdata)
   );

   gwm_ram #(.WIDTH(8), .DEPTH(SUBJECT_DEPTH)) u_sub_ram (
      .clock   (clock),
      .wr_en   (sub_we),
      .wr_addr (SAW'(slen_ff)),
      .wr_data (req_chan.char_code),
      .rd_addr (sub_raddr),
      .rd_data (sub_rdata)
   );

   gwm_engine #(.PATTERN_DEPTH(PATTERN_DEPTH), .SUBJECT_DEPTH(SUBJECT_DEPTH)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_plen (plen_ff),
      .start_slen (slen_new_w),
      .start_ovf  (sov_new_w || pov_ff),
      .options    (options_ff),
      .pat_addr   (pat_raddr),
      .pat_rdata  (pat_rdata),
      .sub_addr   (sub_raddr),
      .sub_rdata  (sub_rdata),
      .idle       (eng_idle),
      .res_valid  (eng_valid),
      .res_take   (eng_take),
      .result     (eng_result)
   );

endmodule
